### sv/frsu_pkg.sv
// Shared types and constants of the float register stack unit.
// Depends on nothing; used by frsu_alu and float_register_stack_unit.
`timescale 1ns / 1ps
`default_nettype none
package frsu_pkg;

    localparam logic [1:0]  KIND_ZERO   = 2'd0;
    localparam logic [1:0]  KIND_FINITE = 2'd1;
    localparam logic [1:0]  KIND_INF    = 2'd2;

    localparam logic [15:0] CW_DEFAULT  = 16'h037f;
    localparam logic [15:0] CW_MASKS    = 16'h003f;
    localparam logic [15:0] CW_FIXED    = 16'h0340;
    localparam logic [15:0] SW_IE       = 16'h0001;
    localparam logic [15:0] SW_ZE       = 16'h0004;
    localparam logic [15:0] SW_SF       = 16'h0040;
    localparam logic [15:0] SW_ES       = 16'h0080;
    localparam logic [16:0] EXP_BIAS    = 17'd127;

    typedef enum logic [2:0] {
        ACT_INIT  = 3'd0,
        ACT_PUSH  = 3'd1,
        ACT_STORE = 3'd2,
        ACT_LDCW  = 3'd3,
        ACT_ADD   = 3'd4,
        ACT_SUB   = 3'd5,
        ACT_MUL   = 3'd6,
        ACT_DIV   = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_MUL = 2'd1,
        ALU_DIV = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic [1:0]  kind;
        logic        neg;
        logic [15:0] exp;
        logic [23:0] sig;
    } t_fval;

    typedef struct packed {
        logic  done;
        logic  ok;
        logic  zdiv;
        t_fval val;
    } t_alu_res;

endpackage
`default_nettype wire

### sv/frsu_alu.sv
// Shared iterative arithmetic unit: add with normalization, shift-add
// multiply and restoring divide. Depends on frsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module frsu_alu import frsu_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_alu_op  i_op,
    input  wire t_fval    i_a,
    input  wire t_fval    i_b,
    output t_alu_res      o_res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_NORM = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    logic [4:0]   r_cnt, n_cnt;
    logic [48:0]  r_acc, n_acc;
    logic [24:0]  r_q, n_q;
    logic [23:0]  r_dsr, n_dsr;
    logic [15:0]  r_exp, n_exp;
    logic         r_neg, n_neg;
    logic         r_ok, n_ok;
    logic         r_zdiv, n_zdiv;
    t_fval        r_val, n_val;

    logic [16:0]  ea, eb, diff, sh_a, sh_b;
    logic [31:0]  va, vb;
    logic [33:0]  sa, sb, sum, mag;
    logic [24:0]  part, rem2;
    logic         q0, big;

    always_comb begin
        ea    = {i_a.exp[15], i_a.exp};
        eb    = {i_b.exp[15], i_b.exp};
        diff  = ea - eb;
        sh_a  = diff[16] ? (17'd0 - diff) : 17'd0;
        sh_b  = diff[16] ? 17'd0 : diff;
        va    = (|sh_a[16:5]) ? 32'd0 : ({i_a.sig, 8'd0} >> sh_a[4:0]);
        vb    = (|sh_b[16:5]) ? 32'd0 : ({i_b.sig, 8'd0} >> sh_b[4:0]);
        sa    = i_a.neg ? (34'd0 - {2'd0, va}) : {2'd0, va};
        sb    = i_b.neg ? (34'd0 - {2'd0, vb}) : {2'd0, vb};
        sum   = sa + sb;
        mag   = sum[33] ? (34'd0 - sum) : sum;
        q0    = i_a.sig >= i_b.sig;
        part  = r_acc[0] ? ({1'b0, r_acc[47:24]} + {1'b0, r_dsr}) : r_acc[48:24];
        rem2  = {r_acc[23:0], 1'b0};
        big   = r_acc[47];

        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_q     = r_q;
        n_dsr   = r_dsr;
        n_exp   = r_exp;
        n_neg   = r_neg;
        n_ok    = r_ok;
        n_zdiv  = r_zdiv;
        n_val   = r_val;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_ok    = 1'b1;
                    n_zdiv  = 1'b0;
                    n_cnt   = 5'd0;
                    n_state = S_DONE;
                    case (i_op)
                        ALU_ADD: begin
                            if (i_a.kind == KIND_ZERO) begin
                                n_val = i_b;
                            end else if (i_b.kind == KIND_ZERO) begin
                                n_val = i_a;
                            end else if (i_a.kind != KIND_FINITE
                                         || i_b.kind != KIND_FINITE) begin
                                n_ok = 1'b0;
                            end else if (sum == 34'd0) begin
                                n_val = '{KIND_ZERO, 1'b0, 16'd0, 24'd0};
                            end else begin
                                n_acc   = {16'd0, mag[32:0]};
                                n_exp   = diff[16] ? i_b.exp : i_a.exp;
                                n_neg   = sum[33];
                                n_state = S_NORM;
                            end
                        end
                        ALU_MUL: begin
                            n_neg = i_a.neg ^ i_b.neg;
                            if (i_a.kind == KIND_ZERO || i_b.kind == KIND_ZERO) begin
                                n_val = '{KIND_ZERO, n_neg, 16'd0, 24'd0};
                            end else if (i_a.kind != KIND_FINITE
                                         || i_b.kind != KIND_FINITE) begin
                                n_ok = 1'b0;
                            end else begin
                                n_acc   = {25'd0, i_b.sig};
                                n_dsr   = i_a.sig;
                                n_exp   = i_a.exp + i_b.exp;
                                n_state = S_MUL;
                            end
                        end
                        ALU_DIV: begin
                            n_neg = i_a.neg ^ i_b.neg;
                            if (i_b.kind == KIND_ZERO) begin
                                n_zdiv = 1'b1;
                                n_val  = '{KIND_INF, n_neg, 16'd0, 24'd0};
                            end else if (i_a.kind == KIND_ZERO) begin
                                n_val = '{KIND_ZERO, n_neg, 16'd0, 24'd0};
                            end else if (i_a.kind != KIND_FINITE
                                         || i_b.kind != KIND_FINITE
                                         || i_b.sig == 24'd0) begin
                                n_ok = 1'b0;
                            end else begin
                                n_dsr   = i_b.sig;
                                n_acc   = {24'd0, 1'b0,
                                           i_a.sig - (q0 ? i_b.sig : 24'd0)};
                                n_q     = {24'd0, q0};
                                n_exp   = i_a.exp - i_b.exp - 16'd1;
                                n_state = S_DIV;
                            end
                        end
                        default: n_ok = 1'b0;
                    endcase
                end
            end
            S_NORM: begin
                if (r_acc[32]) begin
                    n_acc = r_acc >> 1;
                    n_exp = r_exp + 16'd1;
                end else if (!r_acc[31]) begin
                    n_acc = r_acc << 1;
                    n_exp = r_exp - 16'd1;
                end else begin
                    n_val   = '{KIND_FINITE, r_neg, r_exp, r_acc[31:8]};
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                if (r_cnt == 5'd24) begin
                    n_val   = '{KIND_FINITE, r_neg, r_exp + {15'd0, big},
                                big ? r_acc[47:24] : r_acc[46:23]};
                    n_state = S_DONE;
                end else begin
                    n_acc = {1'b0, part, r_acc[23:1]};
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_DIV: begin
                if (r_cnt == 5'd24) begin
                    n_val   = '{KIND_FINITE, r_neg, r_exp + {15'd0, r_q[24]},
                                r_q[24] ? r_q[24:1] : r_q[23:0]};
                    n_state = S_DONE;
                end else begin
                    n_acc = (rem2 >= {1'b0, r_dsr})
                          ? {24'd0, rem2 - {1'b0, r_dsr}} : {24'd0, rem2};
                    n_q   = {r_q[23:0], rem2 >= {1'b0, r_dsr}};
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_q    <= n_q;
        r_dsr  <= n_dsr;
        r_exp  <= n_exp;
        r_neg  <= n_neg;
        r_ok   <= n_ok;
        r_zdiv <= n_zdiv;
        r_val  <= n_val;
    end

    assign o_res = '{(r_state == S_DONE), r_ok, r_zdiv, r_val};

endmodule
`default_nettype wire

### sv/float_register_stack_unit.sv
// Top level: register stack memory, control/status words and sequencer.
// Depends on frsu_pkg and frsu_alu.
//
//  channel | direction | tdata fields (low bit up)
//  s       | in        | action[2:0] data_bits[34:3] stack_index[37:35]
//  m       | out       | outcome[0] store_bits[32:1] status_now[48:33]
//          |           | control_now[64:49] exception_pending[65] full_slots[73:66]
//
// Init, push and control load go through decode and output; store pop also reads the stack.
// Add runs in the ALU (one normalize shift per cycle in the ALU);
// multiply and divide run 24 ALU steps each.
// One item at a time; s_tready is high only while idle.
// A held result stalls only the next result, not the next input item.
// Reset is synchronous; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module float_register_stack_unit import frsu_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,  // action, data_bits, stack_index
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [79:0]      o_m_tdata   // outcome, store_bits, status_now,
                                         // control_now, exception_pending,
                                         // full_slots
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEC  = 6'b000010,
        S_RDA  = 6'b000100,
        S_RDB  = 6'b001000,
        S_ALU  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state       r_state, n_state;
    t_action      r_act;
    logic [31:0]  r_data;
    logic [2:0]   r_idx;
    logic [2:0]   r_top, n_top;
    logic [7:0]   r_valid, n_valid;
    logic [15:0]  r_cw, n_cw;
    logic [15:0]  r_sw, n_sw;
    logic         r_pend, n_pend;
    t_fval        r_a, n_a;
    logic         r_outcome, n_outcome;
    logic [31:0]  r_store, n_store;
    logic         r_o_tvalid, n_o_tvalid;
    logic [79:0]  r_o_tdata, n_o_tdata;

    t_fval        r_mem [8];
    t_fval        r_rd;
    logic [2:0]   rd_addr, w_addr;
    logic         w_en;
    t_fval        w_data;

    logic         alu_start;
    t_alu_op      alu_op;
    t_fval        alu_b;
    t_alu_res     alu_res;

    logic [7:0]   ef;
    logic [2:0]   push_slot;
    logic [16:0]  enc_exp;
    logic [15:0]  sw_out;

    frsu_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_op    (alu_op),
        .i_a     (r_a),
        .i_b     (alu_b),
        .o_res   (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    assign sw_out      = {r_sw[15:14], r_top, r_sw[10:0]};
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_o_tvalid;
    assign o_m_tdata   = r_o_tdata;

    always_comb begin
        ef        = r_data[30:23];
        push_slot = r_top - 3'd1;
        enc_exp   = {r_rd.exp[15], r_rd.exp} + EXP_BIAS;
        rd_addr   = (r_state == S_DEC) ? r_top : (r_top + r_idx);

        n_state    = r_state;
        n_top      = r_top;
        n_valid    = r_valid;
        n_cw       = r_cw;
        n_sw       = r_sw;
        n_pend     = r_pend;
        n_a        = r_a;
        n_outcome  = r_outcome;
        n_store    = r_store;
        n_o_tvalid = r_o_tvalid;
        n_o_tdata  = r_o_tdata;
        w_en       = 1'b0;
        w_addr     = r_top;
        w_data     = alu_res.val;
        alu_start  = 1'b0;
        alu_b      = r_rd;
        alu_op     = ALU_ADD;

        if (r_o_tvalid && i_m_tready) begin
            n_o_tvalid = 1'b0;
        end

        case (r_act)
            ACT_SUB: alu_b.neg = !r_rd.neg;
            default: alu_b.neg = r_rd.neg;
        endcase
        case (r_act)
            ACT_MUL: alu_op = ALU_MUL;
            ACT_DIV: alu_op = ALU_DIV;
            default: alu_op = ALU_ADD;
        endcase

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_outcome = 1'b0;
                    n_store   = 32'd0;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_OUT;
                case (r_act)
                    ACT_INIT: begin
                        n_top   = 3'd0;
                        n_valid = 8'd0;
                        n_cw    = CW_DEFAULT;
                        n_sw    = 16'd0;
                        n_pend  = 1'b0;
                    end
                    ACT_PUSH: begin
                        if (ef == 8'hff || (ef == 8'd0 && r_data[22:0] != 23'd0)) begin
                            n_outcome = 1'b1;
                        end else if (r_valid[push_slot]) begin
                            n_sw = r_sw | SW_IE | SW_SF;
                            if (!r_cw[0]) begin
                                n_sw   = n_sw | SW_ES;
                                n_pend = 1'b1;
                            end
                        end else begin
                            w_en   = 1'b1;
                            w_addr = push_slot;
                            if (ef == 8'd0) begin
                                w_data = '{KIND_ZERO, r_data[31], 16'd0, 24'd0};
                            end else begin
                                w_data = '{KIND_FINITE, r_data[31],
                                           {8'd0, ef} - 16'd127, {1'b1, r_data[22:0]}};
                            end
                            n_top              = push_slot;
                            n_valid[push_slot] = 1'b1;
                        end
                    end
                    ACT_LDCW: begin
                        n_cw = (r_data[15:0] & CW_MASKS) | CW_FIXED;
                        if (r_sw[7] && ((n_cw[5:0] & r_sw[5:0]) != r_sw[5:0])) begin
                            n_pend = 1'b1;
                        end
                    end
                    default: begin
                        if (!r_valid[r_top]
                            || (r_act != ACT_STORE && !r_valid[r_top + r_idx])) begin
                            n_sw = r_sw | SW_IE | SW_SF;
                            if (!r_cw[0]) begin
                                n_sw   = n_sw | SW_ES;
                                n_pend = 1'b1;
                            end
                        end else begin
                            n_state = S_RDA;
                        end
                    end
                endcase
            end
            S_RDA: begin
                n_a = r_rd;
                if (r_act == ACT_STORE) begin
                    n_state = S_OUT;
                    case (r_rd.kind)
                        KIND_ZERO: n_store = {r_rd.neg, 31'd0};
                        KIND_INF:  n_store = {r_rd.neg, 8'hff, 23'd0};
                        KIND_FINITE: begin
                            if (!enc_exp[16] && enc_exp != 17'd0 && enc_exp < 17'd255
                                && r_rd.sig[23]) begin
                                n_store = {r_rd.neg, enc_exp[7:0], r_rd.sig[22:0]};
                            end else begin
                                n_outcome = 1'b1;
                            end
                        end
                        default: n_outcome = 1'b1;
                    endcase
                    if (!n_outcome) begin
                        n_valid[r_top] = 1'b0;
                        n_top          = r_top + 3'd1;
                    end
                end else begin
                    n_state = S_RDB;
                end
            end
            S_RDB: begin
                alu_start = 1'b1;
                n_state   = S_ALU;
            end
            S_ALU: begin
                if (alu_res.done) begin
                    n_state = S_OUT;
                    if (alu_res.ok) begin
                        w_en = 1'b1;
                        if (alu_res.zdiv) begin
                            n_sw = r_sw | SW_ZE;
                            if (!r_cw[2]) begin
                                n_sw   = n_sw | SW_ES;
                                n_pend = 1'b1;
                            end
                        end
                    end else begin
                        n_outcome = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!r_o_tvalid || i_m_tready) begin
                    n_o_tvalid = 1'b1;
                    n_o_tdata  = {6'd0, r_valid, r_pend, r_cw, sw_out,
                                  r_store, r_outcome};
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_top      <= 3'd0;
            r_valid    <= 8'd0;
            r_cw       <= CW_DEFAULT;
            r_sw       <= 16'd0;
            r_pend     <= 1'b0;
            r_o_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_top      <= n_top;
            r_valid    <= n_valid;
            r_cw       <= n_cw;
            r_sw       <= n_sw;
            r_pend     <= n_pend;
            r_o_tvalid <= n_o_tvalid;
        end
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_act  <= t_action'(i_s_tdata[2:0]);
            r_data <= i_s_tdata[34:3];
            r_idx  <= i_s_tdata[37:35];
        end
        r_a       <= n_a;
        r_outcome <= n_outcome;
        r_store   <= n_store;
        r_o_tdata <= n_o_tdata;
    end

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for float_register_stack_unit: directed and random items
// are sent on the stream input and every result is compared with an internal predictor.
// Depends on frsu_pkg and float_register_stack_unit.
`timescale 1ns / 1ps
module tb_top;
    import frsu_pkg::*;

    typedef struct packed {
        logic [7:0]  full_slots;
        logic        exception_pending;
        logic [15:0] control_now;
        logic [15:0] status_now;
        logic [31:0] store_bits;
        logic        outcome;
    } t_fpu_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [39:0] i_s_tdata = '0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [79:0] o_m_tdata;

    // model of the register stack
    t_fval       regs_m [8];
    logic [7:0]  tags_m;
    logic [2:0]  top_m;
    logic [15:0] cw_m;
    logic [15:0] sw_m;
    logic        pend_m;

    t_fpu_resp   expected_results [$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          failed = 1'b0;

    float_register_stack_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_stack();
        for (int k = 0; k < 8; k++) begin
            regs_m[k] = '{kind: KIND_ZERO, neg: 1'b0, exp: 16'd0, sig: 24'd0};
        end
        tags_m = '0;
        top_m  = 3'd0;
        cw_m   = CW_DEFAULT;
        sw_m   = 16'd0;
        pend_m = 1'b0;
    endfunction

    function automatic void raise_exc(logic [15:0] bits, logic [15:0] mask);
        sw_m = sw_m | bits;
        if ((cw_m & mask) != mask) begin
            sw_m   = sw_m | SW_ES;
            pend_m = 1'b1;
        end
    endfunction

    function automatic bit add_vals(t_fval a, t_fval b, output t_fval r);
        int                ea, eb, e;
        int unsigned       sh;
        longint            va, vb, s;
        longint unsigned   m;
        r = '0;
        if (a.kind == KIND_ZERO) begin
            r = b;
            return 1'b1;
        end
        if (b.kind == KIND_ZERO) begin
            r = a;
            return 1'b1;
        end
        if (a.kind != KIND_FINITE || b.kind != KIND_FINITE) return 1'b0;
        ea = int'($signed(a.exp));
        eb = int'($signed(b.exp));
        e  = (ea >= eb) ? ea : eb;
        m  = 64'(a.sig) << 8;
        sh = e - ea;
        va = (sh >= 32) ? 64'd0 : longint'(m >> sh);
        m  = 64'(b.sig) << 8;
        sh = e - eb;
        vb = (sh >= 32) ? 64'd0 : longint'(m >> sh);
        if (a.neg) va = -va;
        if (b.neg) vb = -vb;
        s = va + vb;
        if (s == 0) return 1'b1;
        r.neg = (s < 0);
        m = (s < 0) ? longint'(-s) : s;
        while (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            e++;
        end
        while (m < 64'h8000_0000) begin
            m = m << 1;
            e--;
        end
        r.kind = KIND_FINITE;
        r.exp  = e[15:0];
        r.sig  = m[31:8];
        return 1'b1;
    endfunction

    function automatic bit mul_vals(t_fval a, t_fval b, output t_fval r);
        longint unsigned p;
        bit              big;
        int              e;
        r     = '0;
        r.neg = a.neg ^ b.neg;
        if (a.kind == KIND_ZERO || b.kind == KIND_ZERO) return 1'b1;
        if (a.kind != KIND_FINITE || b.kind != KIND_FINITE) return 1'b0;
        p   = 64'(a.sig) * 64'(b.sig);
        big = (p >= 64'h8000_0000_0000);
        e   = int'($signed(a.exp)) + int'($signed(b.exp)) + (big ? 1 : 0);
        r.kind = KIND_FINITE;
        r.exp  = e[15:0];
        r.sig  = big ? p[47:24] : p[46:23];
        return 1'b1;
    endfunction

    function automatic bit div_vals(t_fval a, t_fval b, output t_fval r);
        longint unsigned q;
        int              e;
        r     = '0;
        r.neg = a.neg ^ b.neg;
        if (b.kind == KIND_ZERO) begin
            raise_exc(SW_ZE, SW_ZE);
            r.kind = KIND_INF;
            return 1'b1;
        end
        if (a.kind == KIND_ZERO) return 1'b1;
        if (a.kind != KIND_FINITE || b.kind != KIND_FINITE || b.sig == 24'd0) return 1'b0;
        q = (64'(a.sig) << 24) / 64'(b.sig);
        e = int'($signed(a.exp)) - int'($signed(b.exp)) - 1;
        if (q >= 64'h100_0000) begin
            q = q >> 1;
            e++;
        end
        r.kind = KIND_FINITE;
        r.exp  = e[15:0];
        r.sig  = q[23:0];
        return 1'b1;
    endfunction

    function automatic t_fpu_resp predict_fpu(t_action act, logic [31:0] data,
                                              logic [2:0] idx);
        t_fpu_resp  res;
        t_fval      a, b, r;
        logic [2:0] p, q;
        logic [7:0] ef;
        logic [15:0] flagged;
        int         e;
        bit         ok;
        res = '0;
        r   = '0;
        case (act)
            ACT_INIT: clear_stack();
            ACT_PUSH: begin
                ef = data[30:23];
                if (ef == 8'hff || (ef == 8'd0 && data[22:0] != 23'd0)) begin
                    res.outcome = 1'b1;
                end else begin
                    r.neg = data[31];
                    if (ef != 8'd0) begin
                        r.kind = KIND_FINITE;
                        e      = int'(ef) - 127;
                        r.exp  = e[15:0];
                        r.sig  = {1'b1, data[22:0]};
                    end
                    p = top_m - 3'd1;
                    if (tags_m[p]) begin
                        raise_exc(SW_IE | SW_SF, SW_IE);
                    end else begin
                        top_m     = p;
                        regs_m[p] = r;
                        tags_m[p] = 1'b1;
                    end
                end
            end
            ACT_STORE: begin
                a = regs_m[top_m];
                if (!tags_m[top_m]) begin
                    raise_exc(SW_IE | SW_SF, SW_IE);
                end else begin
                    e  = int'($signed(a.exp)) + 127;
                    ok = 1'b1;
                    if (a.kind == KIND_ZERO) begin
                        res.store_bits = {a.neg, 31'd0};
                    end else if (a.kind == KIND_INF) begin
                        res.store_bits = {a.neg, 8'hff, 23'd0};
                    end else if (e <= 0 || e >= 255 || !a.sig[23]) begin
                        ok = 1'b0;
                    end else begin
                        res.store_bits = {a.neg, e[7:0], a.sig[22:0]};
                    end
                    if (ok) begin
                        tags_m[top_m] = 1'b0;
                        top_m = top_m + 3'd1;
                    end else begin
                        res.outcome = 1'b1;
                    end
                end
            end
            ACT_LDCW: begin
                flagged = sw_m & CW_MASKS;
                cw_m    = (data[15:0] & CW_MASKS) | CW_FIXED;
                if ((sw_m & SW_ES) != 16'd0 && (cw_m & flagged) != flagged) pend_m = 1'b1;
            end
            default: begin
                p = top_m;
                q = top_m + idx;
                if (!tags_m[p] || !tags_m[q]) begin
                    raise_exc(SW_IE | SW_SF, SW_IE);
                end else begin
                    a = regs_m[p];
                    b = regs_m[q];
                    case (act)
                        ACT_SUB: begin
                            b.neg = ~b.neg;
                            ok = add_vals(a, b, r);
                        end
                        ACT_ADD: ok = add_vals(a, b, r);
                        ACT_MUL: ok = mul_vals(a, b, r);
                        default: ok = div_vals(a, b, r);
                    endcase
                    if (ok) regs_m[p] = r;
                    else res.outcome = 1'b1;
                end
            end
        endcase
        sw_m[13:11]           = top_m;
        res.status_now        = sw_m;
        res.control_now       = cw_m;
        res.exception_pending = pend_m;
        res.full_slots        = tags_m;
        return res;
    endfunction

    task automatic send_item(t_action act, logic [31:0] data, logic [2:0] idx);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'd0, idx, data, act};
        do @(posedge i_clk); while (!o_s_tready);
        expected_results.push_back(predict_fpu(act, data, idx));
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // receive and check results
    always @(posedge i_clk) begin
        t_fpu_resp got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_fpu_resp'(o_m_tdata[73:0]);
            if (expected_results.size() == 0) begin
                $error("unexpected result %h", o_m_tdata);
                failed = 1'b1;
            end else begin
                want = expected_results.pop_front();
                if (got.outcome !== want.outcome) begin
                    $error("outcome exp %h got %h", want.outcome, got.outcome);
                    failed = 1'b1;
                end
                if (got.store_bits !== want.store_bits) begin
                    $error("store_bits exp %h got %h", want.store_bits, got.store_bits);
                    failed = 1'b1;
                end
                if (got.status_now !== want.status_now) begin
                    $error("status_now exp %h got %h", want.status_now, got.status_now);
                    failed = 1'b1;
                end
                if (got.control_now !== want.control_now) begin
                    $error("control_now exp %h got %h", want.control_now, got.control_now);
                    failed = 1'b1;
                end
                if (got.exception_pending !== want.exception_pending) begin
                    $error("exception_pending exp %h got %h", want.exception_pending,
                           got.exception_pending);
                    failed = 1'b1;
                end
                if (got.full_slots !== want.full_slots) begin
                    $error("full_slots exp %h got %h", want.full_slots, got.full_slots);
                    failed = 1'b1;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_formats();
        send_item(ACT_INIT, 32'h0, 3'd0);
        send_item(ACT_PUSH, 32'h7f7f_ffff, 3'd0);
        send_item(ACT_PUSH, 32'h0080_0000, 3'd0);
        send_item(ACT_PUSH, 32'h8000_0000, 3'd0);
        send_item(ACT_PUSH, 32'h7f80_0000, 3'd0);
        send_item(ACT_PUSH, 32'hffc0_0001, 3'd0);
        send_item(ACT_PUSH, 32'h0000_0001, 3'd0);
        repeat (4) send_item(ACT_STORE, 32'h0, 3'd0);
    endtask

    task automatic test_zero_operands();
        send_item(ACT_PUSH, 32'h0000_0000, 3'd0);
        send_item(ACT_PUSH, 32'h8000_0000, 3'd0);
        send_item(ACT_SUB, 32'h0, 3'd1);
        send_item(ACT_DIV, 32'h0, 3'd1);
        send_item(ACT_ADD, 32'h0, 3'd1);
        send_item(ACT_MUL, 32'h0, 3'd7);
        send_item(ACT_PUSH, 32'hbfc0_0000, 3'd0);
        send_item(ACT_DIV, 32'h0, 3'd1);
        send_item(ACT_SUB, 32'h0, 3'd0);
        send_item(ACT_STORE, 32'h0, 3'd0);
    endtask

    task automatic test_exceptions();
        send_item(ACT_LDCW, 32'hffff_ffc0, 3'd0);
        send_item(ACT_INIT, 32'h0, 3'd0);
        send_item(ACT_LDCW, 32'h0000_0000, 3'd0);
        send_item(ACT_STORE, 32'h0, 3'd0);
        send_item(ACT_LDCW, 32'h0000_ffff, 3'd0);
    endtask

    task automatic test_exponent_wrap();
        send_item(ACT_INIT, 32'h0, 3'd0);
        send_item(ACT_PUSH, 32'h7e80_0000, 3'd0);
        repeat (9) send_item(ACT_MUL, 32'h0, 3'd0);
        send_item(ACT_STORE, 32'h0, 3'd0);
    endtask

    function automatic logic [31:0] rand_word();
        if ($urandom_range(9) == 0) return $urandom;
        if ($urandom_range(9) == 0) return {1'($urandom), 31'd0};
        return {1'($urandom), 8'($urandom_range(147, 107)), 23'($urandom)};
    endfunction

    task automatic run_random(int count, int idle_pct, int stall_pct);
        int r;
        int depth;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            r     = $urandom_range(99);
            depth = $countones(tags_m);
            if (depth < 2 && r >= 10) r = 20;
            if (r < 2) send_item(ACT_INIT, $urandom, 3'($urandom));
            else if (r < 8) send_item(ACT_LDCW, $urandom, 3'($urandom));
            else if (r < 38) send_item(ACT_PUSH, rand_word(), 3'($urandom));
            else if (r < 55) send_item(ACT_STORE, $urandom, 3'($urandom));
            else send_item(t_action'($urandom_range(ACT_DIV, ACT_ADD)), $urandom,
                           3'($urandom_range(depth > 0 ? depth - 1 : 0)));
        end
        wait_drained();
    endtask

    initial begin
        clear_stack();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_formats();
        test_zero_operands();
        wait_drained();
        test_exceptions();
        test_exponent_wrap();
        wait_drained();
        run_random(450, 0, 0);
        run_random(450, 88, 0);
        run_random(450, 0, 88);
        run_random(450, 7, 7);
        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

### float_register_stack_unit.f
sv/frsu_pkg.sv
sv/frsu_alu.sv
sv/float_register_stack_unit.sv
tb/tb_top.sv
